// ===== rtl/string_to_integer_parser_top_defines.svh =====
// Assertion macros for the string to integer parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef STRING_TO_INTEGER_PARSER_TOP_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stip_pkg.sv =====
// Shared types, constants and helper function of the string to integer parser.
// No dependencies; every other file but the defines header imports this package.
`timescale 1ns / 1ps

package stip_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CONSUMED_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned PROD_W     = VALUE_W + BASE_W;

  localparam logic [COUNT_W-1:0] CNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = CFG_IDX_W'(1);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_TEN   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
  localparam logic [DIGIT_W-1:0] NO_DIGIT  = DIGIT_W'(36);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

  localparam logic [VALUE_W-1:0] S64_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] S64_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS
  } phase_e;

  // Character class of the current item, seen against the base in force
  typedef struct packed {
    logic is_space;
    logic is_sign;
    logic is_minus;
    logic is_zero;
    logic is_x;
    logic digit_ok;
    logic digit_hex;
    logic base_zero;
    logic base_hex;
  } status_t;

  typedef struct packed {
    logic step;
    logic take;
    logic mark;
    logic set_sign;
    logic load_digit;
    logic accumulate;
    logic base_prefix;
    logic base_ten;
    logic base_hex;
    logic emit;
    logic have_digits;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]    value_bits;
    logic [CONSUMED_W-1:0] consumed_count;
    logic                  range_error;
    logic                  no_digits;
    logic                  count_saturated;
  } result_t;

  // Digit value 0..35, NO_DIGIT for anything else
  function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d = DIGIT_W'(c - CH_LC_A) + DIGIT_W'(10);
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d = DIGIT_W'(c - CH_UC_A) + DIGIT_W'(10);
    end
    return d;
  endfunction

endpackage

// ===== rtl/stip_if.sv =====
// Channel interfaces of the string to integer parser: input, result, config.
// Depends on stip_pkg.
`timescale 1ns / 1ps

interface stip_in_if;
  import stip_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              first_char;
  modport source (output valid, char_in, first_char, input ready);
  modport sink   (input valid, char_in, first_char, output ready);
endinterface

interface stip_out_if;
  import stip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_W-1:0]    value_bits;
  logic [CONSUMED_W-1:0] consumed_count;
  logic                  range_error;
  logic                  no_digits;
  logic                  count_saturated;
  modport source (output valid, value_bits, consumed_count, range_error, no_digits,
                  count_saturated, input ready);
  modport sink   (input valid, value_bits, consumed_count, range_error, no_digits,
                  count_saturated, output ready);
endinterface

interface stip_cfg_if;
  import stip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/stip_ctrl.sv =====
// Parse controller: phase state machine issuing one command bundle per item.
// Depends on stip_pkg.
`timescale 1ns / 1ps

module stip_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              first_char_i,
  input  stip_pkg::status_t status_i,
  output stip_pkg::cmd_t    cmd_o
);
  import stip_pkg::*;

  phase_e phase_q, phase_d;
  phase_e phase_v;
  logic   zero_prefix;
  phase_e signed_next, digits_next;
  cmd_t   cmd_signed, cmd_digits;

  // A first character opens a new string regardless of the current phase
  assign phase_v     = first_char_i ? PH_LEAD : phase_q;
  assign zero_prefix = status_i.is_zero && (status_i.base_zero || status_i.base_hex);

  assign signed_next = zero_prefix ? PH_ZERO : (status_i.digit_ok ? PH_DIGITS : PH_IDLE);
  assign digits_next = status_i.digit_ok ? PH_DIGITS : PH_IDLE;

  always_comb begin
    phase_d = phase_q;
    if (in_fire_i) begin
      case (phase_v)
        PH_LEAD: begin
          if (status_i.is_space) begin
            phase_d = PH_LEAD;
          end else if (status_i.is_sign) begin
            phase_d = PH_SIGNED;
          end else begin
            phase_d = signed_next;
          end
        end
        PH_SIGNED: phase_d = signed_next;
        PH_ZERO:   phase_d = status_i.is_x ? PH_XSEEN : digits_next;
        PH_XSEEN:  phase_d = status_i.digit_hex ? PH_DIGITS : PH_IDLE;
        PH_DIGITS: phase_d = digits_next;
        default:   phase_d = PH_IDLE;
      endcase
    end
  end

  // Command for the sign-or-first-digit position
  always_comb begin
    cmd_signed = '0;
    if (zero_prefix) begin
      cmd_signed.take        = 1'b1;
      cmd_signed.mark        = 1'b1;
      cmd_signed.load_digit  = 1'b1;
      cmd_signed.base_prefix = 1'b1;
    end else begin
      cmd_signed.base_ten = status_i.base_zero;
      if (status_i.digit_ok) begin
        cmd_signed.take       = 1'b1;
        cmd_signed.mark       = 1'b1;
        cmd_signed.load_digit = 1'b1;
      end else begin
        cmd_signed.emit = 1'b1;
      end
    end
  end

  // Command for a digit position
  always_comb begin
    cmd_digits = '0;
    if (status_i.digit_ok) begin
      cmd_digits.take       = 1'b1;
      cmd_digits.mark       = 1'b1;
      cmd_digits.accumulate = 1'b1;
    end else begin
      cmd_digits.emit        = 1'b1;
      cmd_digits.have_digits = 1'b1;
    end
  end

  always_comb begin
    cmd_o = '0;
    if (in_fire_i) begin
      case (phase_v)
        PH_LEAD: begin
          if (status_i.is_space) begin
            cmd_o.take = 1'b1;
          end else if (status_i.is_sign) begin
            cmd_o.take     = 1'b1;
            cmd_o.set_sign = 1'b1;
          end else begin
            cmd_o = cmd_signed;
          end
        end
        PH_SIGNED: cmd_o = cmd_signed;
        PH_ZERO: begin
          if (status_i.is_x) begin
            cmd_o.take = 1'b1;
          end else begin
            cmd_o = cmd_digits;
          end
        end
        PH_XSEEN: begin
          if (status_i.digit_hex) begin
            cmd_o.take       = 1'b1;
            cmd_o.mark       = 1'b1;
            cmd_o.load_digit = 1'b1;
            cmd_o.base_hex   = 1'b1;
          end else begin
            cmd_o.emit        = 1'b1;
            cmd_o.have_digits = 1'b1;
          end
        end
        PH_DIGITS: cmd_o = cmd_digits;
        default:   cmd_o = '0;
      endcase
      cmd_o.step = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/stip_dp.sv =====
// Parse datapath: config registers, accumulator with multiply-add, counters,
// character classification and result formatting. Depends on stip_pkg.
`timescale 1ns / 1ps

module stip_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stip_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [stip_pkg::CHAR_W-1:0]     char_in_i,
  input  logic                            first_char_i,
  input  stip_pkg::cmd_t                  cmd_i,
  output stip_pkg::status_t               status_o,
  output stip_pkg::result_t               result_o
);
  import stip_pkg::*;

  logic [BASE_W-1:0]  num_base_q;
  logic               signed_mode_q;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] vend_q, vend_d;

  // View of the state as this item sees it: a first character starts clean
  logic               neg_v, ovf_v;
  logic [VALUE_W-1:0] acc_v;
  logic [BASE_W-1:0]  base_v, base_cmp, mul_base;
  logic [COUNT_W-1:0] cnt_v, vend_v, cnt_inc;
  logic [DIGIT_W-1:0] d;
  logic [PROD_W-1:0]  prod;
  logic               carry;
  logic [VALUE_W-1:0] mag, neg_mag, value;
  logic               rerr;

  assign neg_v  = first_char_i ? 1'b0 : neg_q;
  assign ovf_v  = first_char_i ? 1'b0 : ovf_q;
  assign acc_v  = first_char_i ? '0 : acc_q;
  assign base_v = first_char_i ? ((num_base_q > BASE_MAX) ? BASE_MAX : num_base_q) : base_q;
  assign cnt_v  = first_char_i ? '0 : cnt_q;
  assign vend_v = first_char_i ? '0 : vend_q;

  assign d        = digit_val(char_in_i);
  assign base_cmp = (base_v == '0) ? BASE_TEN : base_v;

  always_comb begin
    status_o           = '0;
    status_o.is_space  = (char_in_i == CH_SPACE) || (char_in_i inside {[CH_TAB:CH_CR]});
    status_o.is_sign   = (char_in_i == CH_PLUS) || (char_in_i == CH_MINUS);
    status_o.is_minus  = (char_in_i == CH_MINUS);
    status_o.is_zero   = (char_in_i == CH_ZERO);
    status_o.is_x      = (char_in_i == CH_LC_X) || (char_in_i == CH_UC_X);
    status_o.digit_ok  = (d < base_cmp);
    status_o.digit_hex = (d < DIGIT_W'(BASE_HEX));
    status_o.base_zero = (base_v == '0);
    status_o.base_hex  = (base_v == BASE_HEX);
  end

  // One multiply-add per accumulated digit; carry out of 64 bits flags overflow
  assign mul_base = base_cmp;
  assign prod     = PROD_W'(acc_v) * PROD_W'(mul_base) + PROD_W'(d);
  assign carry    = |prod[PROD_W-1:VALUE_W];

  assign cnt_inc = (cnt_v == CNT_MAX) ? cnt_v : cnt_v + COUNT_W'(1);

  always_comb begin
    neg_d  = neg_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    vend_d = vend_q;
    if (cmd_i.step) begin
      neg_d  = cmd_i.set_sign ? status_o.is_minus : neg_v;
      ovf_d  = ovf_v;
      acc_d  = acc_v;
      if (cmd_i.load_digit) begin
        acc_d = VALUE_W'(d);
      end else if (cmd_i.accumulate && !ovf_v) begin
        if (carry) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[VALUE_W-1:0];
        end
      end
      if (cmd_i.base_prefix) begin
        base_d = (base_v == '0) ? BASE_OCT : BASE_HEX;
      end else if (cmd_i.base_hex) begin
        base_d = BASE_HEX;
      end else if (cmd_i.base_ten) begin
        base_d = BASE_TEN;
      end else begin
        base_d = base_v;
      end
      cnt_d  = cmd_i.take ? cnt_inc : cnt_v;
      vend_d = (cmd_i.take && cmd_i.mark) ? cnt_inc : vend_v;
    end
  end

  // Clamp to the signed or unsigned 64-bit range
  assign mag     = ovf_v ? '1 : acc_v;
  assign neg_mag = VALUE_W'(0) - mag;

  always_comb begin
    value = '0;
    rerr  = 1'b0;
    if (cmd_i.have_digits) begin
      if (signed_mode_q) begin
        if (neg_v) begin
          if (mag > S64_MIN) begin
            value = S64_MIN;
            rerr  = 1'b1;
          end else begin
            value = neg_mag;
          end
        end else begin
          if (mag > S64_MAX) begin
            value = S64_MAX;
            rerr  = 1'b1;
          end else begin
            value = mag;
          end
        end
      end else begin
        if (ovf_v) begin
          value = '1;
          rerr  = 1'b1;
        end else begin
          value = neg_v ? neg_mag : mag;
        end
      end
    end
  end

  always_comb begin
    result_o.value_bits      = value;
    result_o.consumed_count  = cmd_i.have_digits ? CONSUMED_W'(vend_v) : '0;
    result_o.range_error     = rerr;
    result_o.no_digits       = !cmd_i.have_digits;
    result_o.count_saturated = (cnt_v == CNT_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_base_q    <= BASE_RESET;
      signed_mode_q <= 1'b1;
      neg_q         <= 1'b0;
      acc_q         <= '0;
      ovf_q         <= 1'b0;
      base_q        <= BASE_RESET;
      cnt_q         <= '0;
      vend_q        <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_NUMBER_BASE) begin
        num_base_q <= cfg_data_i[BASE_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_SIGNED_MODE) begin
        signed_mode_q <= cfg_data_i[0];
      end
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      base_q <= base_d;
      cnt_q  <= cnt_d;
      vend_q <= vend_d;
    end
  end

endmodule

// ===== rtl/stip_outbuf.sv =====
// Result output register with one skid entry behind it.
// Depends on stip_pkg.
`timescale 1ns / 1ps

module stip_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stip_pkg::result_t result_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stip_pkg::result_t result_o
);
  import stip_pkg::*;

  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    out_fire;

  assign out_fire    = out_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = result_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== rtl/string_to_integer_parser_top.sv =====
// Throughput: one character item per cycle unless input stalls; each is parsed in the cycle it is accepted.
// The result of a number is registered in the output buffer when the item that ends it is accepted.
// The input stalls only while both the output register and its skid entry hold results.
// Reset (async, active low): no string open, base 10, signed clamping, output empty.
// Config writes are taken every cycle; registers beyond the list are ignored.
// Depends on stip_pkg, stip_if, stip_ctrl, stip_dp, stip_outbuf and the defines header.
`timescale 1ns / 1ps
`include "string_to_integer_parser_top_defines.svh"

module string_to_integer_parser_top (
  input logic        clk_i,
  input logic        rst_ni,
  stip_in_if.sink    in_i,
  stip_cfg_if.sink   cfg_i,
  stip_out_if.source out_o
);
  import stip_pkg::*;

  logic    in_fire;
  logic    in_ready;
  logic    cfg_we;
  status_t status;
  cmd_t    cmd;
  result_t result_new;
  result_t result_out;
  logic    out_valid;

  // Config writes never stall
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  // Controller: decides per item what the datapath does and when a number ends
  stip_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .first_char_i (in_i.first_char),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Datapath: classify the character, accumulate, count and format the result
  stip_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .char_in_i    (in_i.char_in),
    .first_char_i (in_i.first_char),
    .cmd_i        (cmd),
    .status_o     (status),
    .result_o     (result_new)
  );

  // Hold finished results so the parser keeps taking characters while output stalls, until the skid entry fills
  stip_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.emit),
    .result_i    (result_new),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .result_o    (result_out)
  );

  assign out_o.valid           = out_valid;
  assign out_o.value_bits      = result_out.value_bits;
  assign out_o.consumed_count  = result_out.consumed_count;
  assign out_o.range_error     = result_out.range_error;
  assign out_o.no_digits       = result_out.no_digits;
  assign out_o.count_saturated = result_out.count_saturated;

  // A result is only produced by an accepted item
  `STIP_ASSERT_NOW(a_emit_on_fire, cmd.emit, in_fire, "result produced without an accepted item")
  // A string without digits reports zero value, zero count and no range error
  `STIP_ASSERT_NOW(a_no_digits_zero, out_valid && out_o.no_digits,
    out_o.value_bits == '0 && out_o.consumed_count == '0 && !out_o.range_error,
    "no-digit result carries nonzero fields")
  // Input backpressure only happens with the output register full
  `STIP_ASSERT_NOW(a_stall_needs_full, !in_ready, out_valid, "input stalled with empty output")
  // A result pushed into an empty output shows up next cycle
  `STIP_ASSERT_NEXT(a_push_visible, cmd.emit && !out_valid, out_valid,
    "pushed result not visible")

endmodule
